### hw/rtl/adi_pkg.sv
// Shared widths, reset values and event codes for the averaged distance interlock.
package adi_pkg;

  localparam int DIST_W     = 16;
  localparam int CARD_W     = 16;
  localparam int TRANS_W    = 2;
  localparam int WINDOW_DEF = 5;

  localparam logic [DIST_W-1:0] THRESHOLD_RESET = DIST_W'(1000);

  localparam logic [TRANS_W-1:0] TR_NONE    = 2'd0;
  localparam logic [TRANS_W-1:0] TR_TRIP    = 2'd1;
  localparam logic [TRANS_W-1:0] TR_RESTORE = 2'd2;

  typedef struct packed {
    logic [DIST_W-1:0] avg;
    logic [CARD_W-1:0] card;
  } adi_item_t;

endpackage

### hw/rtl/adi_in_if.sv
// Sample channel: raw distance and card ID with a valid/ready handshake.
interface adi_in_if;
  logic                      valid;
  logic                      ready;
  logic [adi_pkg::DIST_W-1:0] raw_distance;
  logic [adi_pkg::CARD_W-1:0] card_in;

  modport source (output valid, output raw_distance, output card_in, input ready);
  modport sink   (input valid, input raw_distance, input card_in, output ready);
endinterface

### hw/rtl/adi_out_if.sv
// Result channel: average, stop state, latched card and transition event.
interface adi_out_if;
  logic                        valid;
  logic                        ready;
  logic [adi_pkg::DIST_W-1:0]  average_distance;
  logic                        stopped;
  logic [adi_pkg::CARD_W-1:0]  card_out;
  logic [adi_pkg::TRANS_W-1:0] transition;

  modport source (output valid, output average_distance, output stopped,
                  output card_out, output transition, input ready);
  modport sink   (input valid, input average_distance, input stopped,
                  input card_out, input transition, output ready);
endinterface

### hw/rtl/adi_cell.sv
// One window cell: holds a sample and hands it to its neighbour on each transfer.
module adi_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       shift_en,
  input  logic [adi_pkg::DIST_W-1:0] sample_in,
  output logic [adi_pkg::DIST_W-1:0] sample_out
);
  import adi_pkg::*;

  logic [DIST_W-1:0] sample_r;
  logic [DIST_W-1:0] sample_nxt;

  always_comb begin
    sample_nxt = shift_en ? sample_in : sample_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_r <= '0;
    end else begin
      sample_r <= sample_nxt;
    end
  end

  assign sample_out = sample_r;
endmodule

### hw/rtl/adi_interlock.sv
// Interlock stage: stop latch, card latch and the output register.
module adi_interlock (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        load,
  input  adi_pkg::adi_item_t          item,
  input  logic [adi_pkg::DIST_W-1:0]  threshold,
  input  logic                        out_ready,
  output logic                        ready,
  output logic                        out_valid,
  output logic [adi_pkg::DIST_W-1:0]  average_distance,
  output logic                        stopped,
  output logic [adi_pkg::CARD_W-1:0]  card_out,
  output logic [adi_pkg::TRANS_W-1:0] transition
);
  import adi_pkg::*;

  logic               stop_r, stop_nxt;
  logic [CARD_W-1:0]  card_r, card_nxt;
  logic               valid_r, valid_nxt;
  logic [DIST_W-1:0]  avg_r;
  logic [TRANS_W-1:0] trans_r, trans_nxt;
  logic [CARD_W-1:0]  card_tmp;

  assign ready = !valid_r || out_ready;

  always_comb begin
    // a fresh card overwrites the latch before the interlock decision
    card_tmp  = (item.card != '0) ? item.card : card_r;
    stop_nxt  = stop_r;
    card_nxt  = card_tmp;
    trans_nxt = TR_NONE;
    if (item.avg < threshold) begin
      stop_nxt = 1'b1;
      if (!stop_r) begin
        trans_nxt = TR_TRIP;
      end
    end else begin
      stop_nxt = 1'b0;
      if (stop_r) begin
        card_nxt  = '0;
        trans_nxt = TR_RESTORE;
      end
    end
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_r  <= 1'b0;
      card_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (load) begin
        stop_r <= stop_nxt;
        card_r <= card_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      avg_r   <= item.avg;
      trans_r <= trans_nxt;
    end
  end

  assign out_valid        = valid_r;
  assign average_distance = avg_r;
  assign stopped          = stop_r;
  assign card_out         = card_r;
  assign transition       = trans_r;

  a_trip_sets_stop: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && trans_r == TR_TRIP |-> stop_r)
    else $error("trip event without stop latched");

  a_restore_clears: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && trans_r == TR_RESTORE |-> !stop_r && card_r == '0)
    else $error("restore event left stop or card latched");

  a_release_on_high: assert property (@(posedge clk) disable iff (!rst_n)
    load && !(item.avg < threshold) |=> !stop_r)
    else $error("stop still latched after average at or above threshold");
endmodule

### hw/rtl/averaged_distance_interlock.sv
// Top level of the averaged distance interlock: cell chain, running sum, divide, interlock.
// Throughput: one sample per cycle when the output is not back-pressured; the stages are the
// running-sum register, the reciprocal multiply register and the interlock output register.
// Reset (rst_n low, synchronous): window cells and sum cleared, stop released,
// latched card cleared, stop threshold set to 1000, pipeline emptied.
module averaged_distance_interlock #(
  parameter int WINDOW = adi_pkg::WINDOW_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  adi_in_if.sink                     in_ch,
  adi_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [adi_pkg::DIST_W-1:0] cfg_wdata
);
  import adi_pkg::*;

  localparam int SUM_W   = DIST_W + $clog2(WINDOW);
  localparam int SHIFT_W = SUM_W + $clog2(WINDOW);
  localparam int M_W     = SHIFT_W + 1;
  localparam int P_W     = SUM_W + M_W;
  // ceil(2^SHIFT_W / WINDOW): exact truncating quotient for every window sum
  localparam logic [M_W-1:0] RECIP =
    M_W'(((64'd1 << SHIFT_W) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

  logic [DIST_W-1:0] thr_r;
  logic              accept;
  logic              ready_a, ready_b, ready_c;
  logic              v_a_r, v_a_nxt;
  logic              v_b_r;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [CARD_W-1:0] card_a_r, card_b_r;
  logic [P_W-1:0]    prod_r;
  adi_item_t         item_c;
  logic [DIST_W-1:0] chain [WINDOW+1];

  assign accept  = in_ch.valid && ready_a;
  assign ready_b = !v_b_r || ready_c;
  assign ready_a = !v_a_r || ready_b;
  assign in_ch.ready = ready_a;

  // the row of cells: each transfer pushes the new sample in and the oldest out
  assign chain[0] = in_ch.raw_distance;
  for (genvar k = 0; k < WINDOW; k++) begin : g_cell
    adi_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .shift_en   (accept),
      .sample_in  (chain[k]),
      .sample_out (chain[k+1])
    );
  end

  always_comb begin
    sum_nxt = sum_r + SUM_W'(in_ch.raw_distance) - SUM_W'(chain[WINDOW]);
    if (accept) begin
      v_a_nxt = 1'b1;
    end else if (ready_b) begin
      v_a_nxt = 1'b0;
    end else begin
      v_a_nxt = v_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THRESHOLD_RESET;
      sum_r <= '0;
      v_a_r <= 1'b0;
      v_b_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
      if (accept) begin
        sum_r <= sum_nxt;
      end
      v_a_r <= v_a_nxt;
      if (ready_b) begin
        v_b_r <= v_a_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      card_a_r <= in_ch.card_in;
    end
    if (ready_b && v_a_r) begin
      prod_r   <= P_W'(sum_r) * P_W'(RECIP);
      card_b_r <= card_a_r;
    end
  end

  assign item_c.avg  = prod_r[SHIFT_W +: DIST_W];
  assign item_c.card = card_b_r;

  adi_interlock u_interlock (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (v_b_r && ready_c),
    .item             (item_c),
    .threshold        (thr_r),
    .out_ready        (out_ch.ready),
    .ready            (ready_c),
    .out_valid        (out_ch.valid),
    .average_distance (out_ch.average_distance),
    .stopped          (out_ch.stopped),
    .card_out         (out_ch.card_out),
    .transition       (out_ch.transition)
  );

  a_accept_fills_a: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> v_a_r)
    else $error("transferred sample not held in first stage");

  a_hold_sum: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(sum_r))
    else $error("window sum changed without a transfer");

  a_stage_b_moves: assert property (@(posedge clk) disable iff (!rst_n)
    v_b_r && ready_c |=> out_ch.valid)
    else $error("result lost between multiply and output stage");
endmodule

### test/averaged_distance_interlock_tb.sv
// Self-checking testbench for the averaged distance interlock: shadow model, stimulus and checks.
module averaged_distance_interlock_tb;
  import adi_pkg::*;

  class interlock_shadow;
    localparam int WIN = WINDOW_DEF;

    typedef struct {
      logic [DIST_W-1:0]  avg;
      logic               stopped;
      logic [CARD_W-1:0]  card;
      logic [TRANS_W-1:0] trans;
    } tick_t;

    logic [DIST_W-1:0] ring [WIN];
    int unsigned       slot;
    logic              stop_on;
    logic [CARD_W-1:0] card_held;
    logic [DIST_W-1:0] threshold;
    tick_t             ticks_due [$];
    int unsigned       faults;
    int unsigned       matched;

    function new();
      for (int k = 0; k < WIN; k++) ring[k] = '0;
      slot      = 0;
      stop_on   = 1'b0;
      card_held = '0;
      threshold = THRESHOLD_RESET;
      faults    = 0;
      matched   = 0;
    endfunction

    function void set_threshold(logic [DIST_W-1:0] value);
      threshold = value;
    endfunction

    // Work out the tick that one transferred sample gives and queue it.
    function void take_sample(logic [DIST_W-1:0] dist_mm, logic [CARD_W-1:0] card);
      logic [31:0] total;
      tick_t       t;
      ring[slot] = dist_mm;
      slot = (slot + 1 == WIN) ? 0 : slot + 1;
      total = '0;
      for (int k = 0; k < WIN; k++) total += ring[k];
      t.avg   = DIST_W'(total / WIN);
      t.trans = TR_NONE;
      if (card != '0) card_held = card;
      if (t.avg < threshold) begin
        if (!stop_on) begin
          stop_on = 1'b1;
          t.trans = TR_TRIP;
        end
      end else if (stop_on) begin
        // a release drops the latched card, even one latched this tick
        stop_on   = 1'b0;
        card_held = '0;
        t.trans   = TR_RESTORE;
      end
      t.stopped = stop_on;
      t.card    = card_held;
      ticks_due.push_back(t);
    endfunction

    function void field_ok(string name, int unsigned exp, int unsigned act);
      if (exp != act) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp, act);
        faults++;
      end
    endfunction

    function void match_tick(logic [DIST_W-1:0] avg, logic stopped,
                             logic [CARD_W-1:0] card, logic [TRANS_W-1:0] trans);
      tick_t t;
      if (ticks_due.size() == 0) begin
        $display("%0t: unexpected result: expected none, %s %0d stopped %0d card %0d trans %0d",
                 $time, "actual avg", avg, stopped, card, trans);
        faults++;
      end else begin
        t = ticks_due.pop_front();
        field_ok("average_distance", t.avg, avg);
        field_ok("stopped", t.stopped, stopped);
        field_ok("card_out", t.card, card);
        field_ok("transition", t.trans, trans);
      end
      matched++;
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [DIST_W-1:0] cfg_wdata;
  bit                quiet;

  interlock_shadow shadow;

  adi_in_if  in_if ();
  adi_out_if out_if ();

  averaged_distance_interlock dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if),
    .out_ch   (out_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic send_sample(input logic [DIST_W-1:0] dist_mm, input logic [CARD_W-1:0] card);
    in_if.valid        <= 1'b1;
    in_if.raw_distance <= dist_mm;
    in_if.card_in      <= card;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    shadow.take_sample(dist_mm, card);
  endtask

  task automatic idle_input(input int unsigned cycles);
    in_if.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Drop valid and hold until every queued tick has come back.
  task automatic drain;
    in_if.valid <= 1'b0;
    while (shadow.ticks_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [DIST_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    shadow.set_threshold(value);
  endtask

  task automatic run_random(input int unsigned count, input logic [DIST_W-1:0] thr,
                            input bit gaps);
    int                spread;
    int                v;
    logic [DIST_W-1:0] dist_mm;
    logic [CARD_W-1:0] card;
    for (int n = 0; n < count; n++) begin
      if (gaps && $urandom_range(0, 5) == 0) idle_input($urandom_range(1, 11));
      case ($urandom_range(0, 5))
        0: dist_mm = DIST_W'($urandom);
        1: dist_mm = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        default: begin
          // keep the samples around the threshold so the average crosses it often
          spread = $urandom_range(1, 4000);
          v = int'(thr) + int'($urandom_range(0, 2 * spread)) - spread;
          if (v < 0) v = 0;
          if (v > 65535) v = 65535;
          dist_mm = DIST_W'(v);
        end
      endcase
      case ($urandom_range(0, 9))
        6, 7, 8: card = CARD_W'($urandom);
        9:       card = $urandom_range(0, 1) ? 16'hFFFF : 16'h0001;
        default: card = '0;
      endcase
      send_sample(dist_mm, card);
    end
    drain();
  endtask

  // Result side: random back-pressure and one long hold-off mid-run.
  initial begin : result_sink
    bit held;
    held = 1'b0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held && shadow.matched >= 400) begin
        held = 1'b1;
        out_if.ready <= 1'b0;
        repeat (60) @(posedge clk);
        out_if.ready <= 1'b1;
      end else if (!quiet && rst_n && $urandom_range(0, 7) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      shadow.match_tick(out_if.average_distance, out_if.stopped, out_if.card_out,
                        out_if.transition);
  end

  initial begin : stimulus
    shadow = new();
    quiet  = 1'b0;
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;
    in_if.valid        <= 1'b0;
    in_if.raw_distance <= '0;
    in_if.card_in      <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Reset threshold: warm-up trip, release, card while normal, card and release together.
    send_sample(16'd3000, 16'h1234);
    send_sample(16'd3000, 16'h0000);
    send_sample(16'd0,    16'hBEEF);
    send_sample(16'd0,    16'h0000);
    send_sample(16'd0,    16'h0000);
    send_sample(16'd0,    16'h0000);
    send_sample(16'hFFFF, 16'hFFFF);
    send_sample(16'hFFFF, 16'h0001);
    send_sample(16'hFFFF, 16'h0000);
    send_sample(16'hFFFF, 16'h0000);
    send_sample(16'hFFFF, 16'h8000);
    send_sample(16'd0,    16'h0000);
    send_sample(16'd4999, 16'h5555);
    send_sample(16'd5000, 16'hAAAA);
    drain();

    // Threshold zero: the stop can never latch.
    write_threshold(16'h0000);
    send_sample(16'd0,    16'h0042);
    send_sample(16'd0,    16'h0000);
    send_sample(16'd1,    16'h0000);
    drain();

    // Threshold at maximum: trips on everything short of a full window at maximum.
    write_threshold(16'hFFFF);
    send_sample(16'hFFFF, 16'h0007);
    send_sample(16'hFFFF, 16'h0000);
    send_sample(16'hFFFF, 16'h0000);
    send_sample(16'hFFFF, 16'h0000);
    send_sample(16'hFFFF, 16'h0000);
    drain();

    write_threshold(DIST_W'($urandom));
    run_random(350, shadow.threshold, 1'b1);
    write_threshold(16'h0000);
    run_random(250, 16'h0000, 1'b1);
    write_threshold(16'hFFFF);
    run_random(250, 16'hFFFF, 1'b1);
    write_threshold(DIST_W'($urandom_range(0, 3000)));
    run_random(350, shadow.threshold, 1'b1);

    quiet = 1'b1;
    write_threshold(THRESHOLD_RESET);
    run_random(450, THRESHOLD_RESET, 1'b0);

    repeat (8) @(posedge clk);
    if (shadow.faults == 0 && shadow.ticks_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #4000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
